### hw/rtl/rwts_pkg.sv
package rwts_pkg;

  localparam int ScreenW = 11;
  localparam int ProjW = 12;
  localparam int PresW = 4;
  localparam int DistW = 24;
  localparam int AddrW = 12;
  localparam int ColorW = 32;
  localparam int TexColW = 12;
  localparam int CfgIdxW = 2;
  localparam int CfgDataW = 12;

  localparam logic [CfgIdxW-1:0] CFG_SCREEN_HEIGHT = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_PROJ_DIST = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_TEX_PRESENT = 2'd2;

  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_SHADE = 1'b1;

  localparam logic [ColorW-1:0] BLACK_OPAQUE = 32'hFF00_0000;

  typedef struct packed {
    logic              req_type;
    logic [1:0]        tex_select;
    logic [AddrW-1:0]  load_addr;
    logic [ColorW-1:0] load_color;
    logic [DistW-1:0]  distance;
    logic              vertical_hit;
    logic              facing_east;
    logic              facing_south;
    logic signed [TexColW-1:0] texture_column;
    logic [ScreenW-1:0] screen_column;
    logic [ScreenW-1:0] screen_row;
  } req_t;

  typedef struct packed {
    logic [ColorW-1:0]  pixel_color;
    logic               in_wall;
    logic [ScreenW-1:0] out_column;
    logic [ScreenW-1:0] out_row;
  } res_t;

endpackage

### hw/rtl/rwts_req_if.sv
interface rwts_req_if;
  logic valid;
  logic ready;
  rwts_pkg::req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### hw/rtl/rwts_res_if.sv
interface rwts_res_if;
  logic valid;
  logic ready;
  rwts_pkg::res_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### hw/rtl/rwts_div.sv
// Pipelined restoring divider: one quotient bit per stage.
module rwts_div #(
  parameter int NumW = 32,
  parameter int DenW = 24,
  parameter int TagW = 8
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  logic            in_valid,
  input  logic [NumW-1:0] num,
  input  logic [DenW-1:0] den,
  input  logic [TagW-1:0] in_tag,
  output logic            out_valid,
  output logic [NumW-1:0] quo,
  output logic [TagW-1:0] out_tag
);

  logic [NumW-1:0] rem_s [NumW+1];
  logic [NumW-1:0] q_s   [NumW+1];
  logic [NumW-1:0] n_s   [NumW+1];
  logic [DenW-1:0] d_s   [NumW+1];
  logic [TagW-1:0] t_s   [NumW+1];
  logic            v_s   [NumW+1];

  assign rem_s[0] = '0;
  assign q_s[0] = '0;
  assign n_s[0] = num;
  assign d_s[0] = den;
  assign t_s[0] = in_tag;
  assign v_s[0] = in_valid;

  for (genvar i = 0; i < NumW; i++) begin : g_stage
    logic [NumW:0] trial;
    logic [NumW:0] diff;
    assign trial = {rem_s[i], n_s[i][NumW-1-i]};
    assign diff = trial - {{(NumW+1-DenW){1'b0}}, d_s[i]};
    always_ff @(posedge clk) begin
      if (rst) begin
        v_s[i+1] <= 1'b0;
      end else if (en) begin
        v_s[i+1] <= v_s[i];
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        if (!diff[NumW]) begin
          rem_s[i+1] <= diff[NumW-1:0];
          q_s[i+1] <= {q_s[i][NumW-2:0], 1'b1};
        end else begin
          rem_s[i+1] <= trial[NumW-1:0];
          q_s[i+1] <= {q_s[i][NumW-2:0], 1'b0};
        end
        n_s[i+1] <= n_s[i];
        d_s[i+1] <= d_s[i];
        t_s[i+1] <= t_s[i];
      end
    end
  end

  // A zero divisor gives all ones; callers handle it on their own.
  assign out_valid = v_s[NumW];
  assign quo = q_s[NumW];
  assign out_tag = t_s[NumW];

endmodule

### hw/rtl/rwts_tex_mem.sv
// Texture memory: one write port, one registered read port.
module rwts_tex_mem #(
  parameter int AW = 14
) (
  input  logic                       clk,
  input  logic                       we,
  input  logic [AW-1:0]              waddr,
  input  logic [rwts_pkg::ColorW-1:0] wdata,
  input  logic                       re,
  input  logic [AW-1:0]              raddr,
  output logic [rwts_pkg::ColorW-1:0] rdata
);

  logic [rwts_pkg::ColorW-1:0] mem [2**AW];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### hw/rtl/raycast_wall_texel_shader.sv
// Channel | Dir | Word                       | Accept
// req     | in  | rwts_pkg::req_t (load/shade) | valid && ready
// res     | out | rwts_pkg::res_t (shade only) | valid && ready
// cfg     | in  | cfg_we, cfg_index, cfg_data  | cfg_we
// One word per cycle sustained unless a held result stalls the pipeline. A shade
// word passes the wall height divider (27 stages with the default sizes), two span
// registers, the texel row divider (18 stages), the texture read and the output
// register, in that order. Loads write the memory in order with shades.
// Reset is synchronous and clears only control state; the memory is not cleared.
// The whole pipeline advances only when the output register is free or taken.
module raycast_wall_texel_shader #(
  parameter int TILE_SIZE = 64,
  parameter int TEX_SIZE = 64
) (
  input  logic clk,
  input  logic rst,
  input  logic cfg_we,
  input  logic [rwts_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [rwts_pkg::CfgDataW-1:0] cfg_data,
  rwts_req_if.sink req,
  rwts_res_if.source res
);

  localparam int TileLog = $clog2(TILE_SIZE);
  localparam int NumW = rwts_pkg::ProjW + TileLog + 8 + 1;
  localparam int SpanW = rwts_pkg::ScreenW + 1;
  localparam int RowNumW = rwts_pkg::ScreenW + TileLog + 1;
  localparam int TexAW = rwts_pkg::AddrW + 2;
  localparam int TexMax = TEX_SIZE - 1;

  typedef struct packed {
    logic              shade;
    logic [1:0]        sel;
    logic [rwts_pkg::AddrW-1:0]  addr;
    logic [rwts_pkg::ColorW-1:0] color;
    logic              zero_dist;
    logic signed [rwts_pkg::TexColW-1:0] tcol;
    logic [rwts_pkg::ScreenW-1:0] col;
    logic [rwts_pkg::ScreenW-1:0] row;
  } tag1_t;

  typedef struct packed {
    logic              shade;
    logic              in_span;
    logic              absent;
    logic [1:0]        sel;
    logic [rwts_pkg::AddrW-1:0]  addr;
    logic [rwts_pkg::ColorW-1:0] color;
    logic [rwts_pkg::AddrW-1:0]  tcol;
    logic [rwts_pkg::ScreenW-1:0] col;
    logic [rwts_pkg::ScreenW-1:0] row;
  } tag2_t;

  logic [rwts_pkg::ScreenW-1:0] screen_height;
  logic [rwts_pkg::ProjW-1:0]   projection_distance;
  logic [rwts_pkg::PresW-1:0]   texture_present;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      screen_height <= rwts_pkg::ScreenW'(480);
      projection_distance <= rwts_pkg::ProjW'(554);
      texture_present <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        rwts_pkg::CFG_SCREEN_HEIGHT: screen_height <= cfg_data[rwts_pkg::ScreenW-1:0];
        rwts_pkg::CFG_PROJ_DIST: projection_distance <= cfg_data;
        rwts_pkg::CFG_TEX_PRESENT: texture_present <= cfg_data[rwts_pkg::PresW-1:0];
        default: ;
      endcase
    end
  end

  // Pipeline enable: the output register is empty or being drained.
  logic out_valid;
  logic en;
  assign en = !out_valid || res.ready;
  assign req.ready = en;

  // Stage A: wall height divider.
  logic [NumW-1:0] num_a;
  tag1_t tag_a_in, tag_a_out;
  logic v_a;
  logic [NumW-1:0] h_quo;
  assign num_a = NumW'({projection_distance, 8'd0}) * NumW'(TILE_SIZE);
  always_comb begin
    tag_a_in.shade = req.data.req_type == rwts_pkg::REQ_SHADE;
    tag_a_in.sel = req.data.tex_select;
    tag_a_in.addr = req.data.load_addr;
    tag_a_in.color = req.data.load_color;
    tag_a_in.zero_dist = req.data.distance == '0;
    tag_a_in.tcol = req.data.texture_column;
    tag_a_in.col = req.data.screen_column;
    tag_a_in.row = req.data.screen_row;
    if (req.data.vertical_hit) begin
      tag_a_in.sel = req.data.facing_east ? 2'd3 : 2'd2;
    end else if (req.data.req_type == rwts_pkg::REQ_SHADE) begin
      tag_a_in.sel = req.data.facing_south ? 2'd1 : 2'd0;
    end
    if (req.data.req_type == rwts_pkg::REQ_LOAD) begin
      tag_a_in.sel = req.data.tex_select;
    end
  end

  rwts_div #(.NumW(NumW), .DenW(rwts_pkg::DistW), .TagW($bits(tag1_t))) u_hdiv (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(req.valid), .num(num_a), .den(req.data.distance), .in_tag(tag_a_in),
    .out_valid(v_a), .quo(h_quo), .out_tag(tag_a_out)
  );

  // Stage B: span and clamp, registered.
  logic [NumW-1:0] h_b;
  logic signed [NumW+1:0] beg_raw, end_raw;
  logic [SpanW-1:0] beg_c, end_c;
  logic v_b;
  tag1_t tag_b;
  logic [NumW-1:0] h_sel;
  assign h_sel = tag_a_out.zero_dist ? num_a : h_quo;
  always_ff @(posedge clk) begin
    if (rst) v_b <= 1'b0;
    else if (en) v_b <= v_a;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      h_b <= h_sel;
      tag_b <= tag_a_out;
    end
  end
  always_comb begin
    beg_raw = $signed({2'b0, NumW'(screen_height >> 1)})
            - $signed({2'b0, NumW'((h_b + 1'b1) >> 1)});
    end_raw = beg_raw + $signed({2'b0, h_b});
    beg_c = beg_raw[NumW+1] ? '0 : SpanW'(beg_raw);
    if (end_raw > $signed({{(NumW+2-rwts_pkg::ScreenW){1'b0}}, screen_height}))
      end_c = SpanW'(screen_height);
    else if (end_raw[NumW+1])
      end_c = '0;
    else
      end_c = SpanW'(end_raw);
  end

  // Stage C: inside test and divider operands.
  logic v_c;
  tag2_t tag_c;
  logic [RowNumW-1:0] rnum_c;
  logic [SpanW-1:0] rden_c;
  logic [rwts_pkg::AddrW-1:0] tcol_cl;
  logic inside_b;
  assign inside_b = ({1'b0, tag_b.row} >= beg_c) && ({1'b0, tag_b.row} < end_c);
  always_comb begin
    if (tag_b.tcol < 0) tcol_cl = '0;
    else if (tag_b.tcol > TexMax) tcol_cl = rwts_pkg::AddrW'(TexMax);
    else tcol_cl = rwts_pkg::AddrW'(tag_b.tcol);
  end
  always_ff @(posedge clk) begin
    if (rst) v_c <= 1'b0;
    else if (en) v_c <= v_b;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      tag_c.shade <= tag_b.shade;
      tag_c.in_span <= inside_b;
      tag_c.absent <= !texture_present[tag_b.sel];
      tag_c.sel <= tag_b.sel;
      tag_c.addr <= tag_b.addr;
      tag_c.color <= tag_b.color;
      tag_c.tcol <= tcol_cl;
      tag_c.col <= tag_b.col;
      tag_c.row <= tag_b.row;
      rnum_c <= RowNumW'(SpanW'({1'b0, tag_b.row} - beg_c)) * RowNumW'(TILE_SIZE);
      rden_c <= end_c - beg_c;
    end
  end

  // Stage D: texel row divider.
  logic v_d;
  tag2_t tag_d;
  logic [RowNumW-1:0] trow_q;
  rwts_div #(.NumW(RowNumW), .DenW(SpanW), .TagW($bits(tag2_t))) u_rdiv (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(v_c), .num(rnum_c), .den(rden_c), .in_tag(tag_c),
    .out_valid(v_d), .quo(trow_q), .out_tag(tag_d)
  );

  // Stage E: texture access. Loads and reads stay in order in one pipeline.
  logic [rwts_pkg::AddrW-1:0] trow_cl;
  logic [rwts_pkg::AddrW-1:0] raddr;
  logic [TexAW-1:0] waddr;
  logic [rwts_pkg::ColorW-1:0] rdata;
  logic we;
  logic v_e;
  tag2_t tag_e;
  assign trow_cl = (trow_q > RowNumW'(TexMax)) ? rwts_pkg::AddrW'(TexMax)
                                                : rwts_pkg::AddrW'(trow_q);
  assign raddr = rwts_pkg::AddrW'(trow_cl * rwts_pkg::AddrW'(TEX_SIZE)) + tag_d.tcol;
  assign waddr = {tag_d.sel, tag_d.addr};
  assign we = en && v_d && !tag_d.shade;

  rwts_tex_mem #(.AW(TexAW)) u_mem (
    .clk(clk), .we(we), .waddr(waddr), .wdata(tag_d.color),
    .re(en), .raddr({tag_d.sel, raddr}), .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) v_e <= 1'b0;
    else if (en) v_e <= v_d && tag_d.shade;
  end
  always_ff @(posedge clk) begin
    if (en) tag_e <= tag_d;
  end

  // Output register.
  rwts_pkg::res_t out_word;
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= v_e;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      out_word.in_wall <= tag_e.in_span;
      out_word.out_column <= tag_e.col;
      out_word.out_row <= tag_e.row;
      if (!tag_e.in_span) out_word.pixel_color <= '0;
      else if (tag_e.absent) out_word.pixel_color <= rwts_pkg::BLACK_OPAQUE;
      else out_word.pixel_color <= rdata;
    end
  end

  assign res.valid = out_valid;
  assign res.data = out_word;

endmodule
